FILE: sv/mrrg_pkg.sv
// Shared types and constants of the ramp generator.
`default_nettype none
package mrrg_pkg;

  localparam logic [2:0] ACT_JUMP = 3'd0;
  localparam logic [2:0] ACT_RAMP = 3'd1;
  localparam logic [2:0] ACT_STOP = 3'd2;
  localparam logic [2:0] ACT_SET  = 3'd3;
  localparam logic [2:0] ACT_TICK = 3'd4;

  localparam logic [15:0] GRAIN_RESET = 16'd20;

  localparam logic [5:0] MUL_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS = 6'd49;
  localparam logic [51:0] MUL_LIMIT = 52'h2_0000_0000_0000;

  localparam logic [47:0] SLOPE_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SLOPE_MIN = 48'h8000_0000_0000;

  typedef enum logic {
    UOP_MUL,
    UOP_DIV
  } unit_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RAMP_CHK,
    ST_EMIT,
    ST_SCH_MUL
  } state_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [23:0]        duration_ms;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [31:0]        out_time_ms;
  } out_item_t;

  typedef struct packed {
    logic       start;
    unit_op_t   op;
    logic [48:0] opa;
    logic [31:0] opb;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [49:0] result;
  } unit_rsp_t;

endpackage
`default_nettype wire

FILE: sv/mrrg_unit.sv
// Shared shift-add multiplier and restoring divider, one bit per cycle.
`default_nettype none
module mrrg_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mrrg_pkg::unit_req_t req,
  output mrrg_pkg::unit_rsp_t   rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  mrrg_pkg::unit_op_t op_r, op_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [50:0]       acc_r, acc_nxt;
  logic [48:0]       shreg_r, shreg_nxt;
  logic [47:0]       opnd_r, opnd_nxt;

  logic [50:0] add_a;
  logic [50:0] add_b;
  logic        cin;
  logic [51:0] sum;
  logic        ge;

  always_comb begin
    if (op_r == mrrg_pkg::UOP_MUL) begin
      add_a = {acc_r[49:0], 1'b0};
      add_b = shreg_r[48] ? {3'b0, opnd_r} : 51'd0;
      cin   = 1'b0;
    end else begin
      add_a = {acc_r[49:0], shreg_r[48]};
      add_b = ~{3'b0, opnd_r};
      cin   = 1'b1;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {51'd0, cin};
    ge  = sum[51];
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    shreg_nxt = shreg_r;
    opnd_nxt  = opnd_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      acc_nxt  = '0;
      if (req.op == mrrg_pkg::UOP_MUL) begin
        shreg_nxt = {req.opb, 17'd0};
        opnd_nxt  = req.opa[47:0];
        cnt_nxt   = mrrg_pkg::MUL_STEPS;
      end else begin
        shreg_nxt = req.opa;
        opnd_nxt  = {24'd0, req.opb[23:0]};
        cnt_nxt   = mrrg_pkg::DIV_STEPS;
      end
    end else if (busy_r) begin
      if (op_r == mrrg_pkg::UOP_MUL) begin
        acc_nxt   = (sum > mrrg_pkg::MUL_LIMIT) ? mrrg_pkg::MUL_LIMIT[50:0] : sum[50:0];
        shreg_nxt = {shreg_r[47:0], 1'b0};
      end else begin
        acc_nxt   = ge ? sum[50:0] : add_a;
        shreg_nxt = {shreg_r[47:0], ge};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= mrrg_pkg::UOP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r   <= acc_nxt;
    shreg_r <= shreg_nxt;
    opnd_r  <= opnd_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = (op_r == mrrg_pkg::UOP_MUL) ? acc_r[49:0] : {1'b0, shreg_r};

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("unit done while still busy");
  a_mul_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && op_r == mrrg_pkg::UOP_MUL) |-> ({1'b0, acc_r} <= mrrg_pkg::MUL_LIMIT))
    else $error("product accumulator above limit");
  a_div_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && op_r == mrrg_pkg::UOP_DIV) |-> (acc_r[50:24] == 27'd0))
    else $error("division remainder out of range");
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != 6'd0)) else $error("busy with zero count");
`endif

endmodule
`default_nettype wire

FILE: sv/message_rate_ramp_generator_top.sv
// Top level of the ramp generator: item decode, line state and step sequencer.
// Usage:
//   Input items (jump, ramp, stop, set, tick) arrive on in_valid/in_ready with
//   in_data; a result item leaves on out_valid/out_ready with out_data.
//   cfg_we/cfg_wdata write the grain interval in milliseconds (reset 20).
//   One item at a time: in_ready is high only while the sequencer is idle.
//   Stop, set, unknown actions and ticks that emit nothing go straight back to
//   idle. Jump and a due tick go through the emit state, followed by a multiply
//   in the shared unit when another step gets scheduled; a zero-duration ramp is
//   handled like a jump. Other ramps run the slope division in the shared unit,
//   then emit if the slope is non-zero and run the schedule multiply if another
//   step gets scheduled; a pending step first needs its advance multiply.
//   The result sits in an output register, so the next item is taken while it
//   waits; a stalled receiver holds the block only when a further result is
//   ready to be written.
//   Reset (rst_n low, synchronous) clears the line state to zero, cancels any
//   pending step and drops out_valid.
`default_nettype none
module message_rate_ramp_generator_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire mrrg_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output mrrg_pkg::out_item_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_wdata
);

  mrrg_pkg::state_t    state_r, state_nxt;
  logic [15:0]         grain_r, grain_nxt;
  logic signed [31:0]  current_r, current_nxt;
  logic signed [31:0]  target_r, target_nxt;
  logic signed [47:0]  slope_r, slope_nxt;
  logic [31:0]         last_r, last_nxt;
  logic                pending_r, pending_nxt;
  logic [31:0]         due_r, due_nxt;
  logic signed [31:0]  sched_r, sched_nxt;
  logic signed [31:0]  lvl_r, lvl_nxt;
  logic [31:0]         tm_r, tm_nxt;
  logic [23:0]         dur_r, dur_nxt;
  logic                out_valid_r, out_valid_nxt;
  mrrg_pkg::out_item_t out_data_r, out_data_nxt;

  mrrg_pkg::unit_req_t req;
  mrrg_pkg::unit_rsp_t rsp;

  logic        slope_neg;
  logic [47:0] slope_mag;
  logic [15:0] g_eff;
  logic [31:0] tdiff;
  logic        reached;
  logic [31:0] adv_ms;
  logic        slope_nz;
  logic        going;
  logic        diff_neg;
  logic [32:0] dmag;
  logic [48:0] quo;
  logic [47:0] slope_div;
  logic        slot_free;

  function automatic logic signed [31:0] add_fin(input logic signed [31:0] base,
                                                 input logic neg,
                                                 input logic [49:0] q);
    logic [35:0] x;
    logic [35:0] s;
    logic        frac_nz;
    begin
      x       = {2'b0, q[49:16]};
      frac_nz = |q[15:0];
      if (neg) begin
        s = {{4{base[31]}}, base} + ~x + {35'd0, ~frac_nz};
      end else begin
        s = {{4{base[31]}}, base} + x;
      end
      if (!s[35] && (s[34:31] != 4'd0)) begin
        add_fin = 32'sh7FFF_FFFF;
      end else if (s[35] && (s[34:31] != 4'hF)) begin
        add_fin = 32'sh8000_0000;
      end else begin
        add_fin = s[31:0];
      end
    end
  endfunction

  mrrg_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    slope_neg = slope_r[47];
    slope_mag = slope_neg ? (~slope_r + 48'd1) : slope_r;
    g_eff     = (grain_r == 16'd0) ? 16'd1 : grain_r;
    tdiff     = in_data.time_ms - due_r;
    reached   = ~tdiff[31];
    adv_ms    = in_data.time_ms - last_r;
    slope_nz  = (slope_r != 48'sd0);
    going     = slope_nz && (slope_neg ? (lvl_r > target_r) : (lvl_r < target_r));
    diff_neg  = (target_r < current_r);
    dmag      = diff_neg ? ({current_r[31], current_r} - {target_r[31], target_r})
                         : ({target_r[31], target_r} - {current_r[31], current_r});
    quo       = rsp.result[48:0];
    if (diff_neg) begin
      slope_div = (quo > {1'b0, mrrg_pkg::SLOPE_MIN}) ? mrrg_pkg::SLOPE_MIN
                                                     : (~quo[47:0] + 48'd1);
    end else begin
      slope_div = (quo[48:47] != 2'b00) ? mrrg_pkg::SLOPE_MAX : quo[47:0];
    end
    slot_free = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mrrg_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.action)
            mrrg_pkg::ACT_JUMP: state_nxt = mrrg_pkg::ST_EMIT;
            mrrg_pkg::ACT_RAMP: begin
              if (in_data.duration_ms == 24'd0) begin
                state_nxt = mrrg_pkg::ST_EMIT;
              end else if (pending_r) begin
                state_nxt = mrrg_pkg::ST_ADV_MUL;
              end else begin
                state_nxt = mrrg_pkg::ST_DIV_START;
              end
            end
            mrrg_pkg::ACT_TICK: begin
              if (pending_r && reached) state_nxt = mrrg_pkg::ST_EMIT;
            end
            default: state_nxt = mrrg_pkg::ST_IDLE;
          endcase
        end
      end
      mrrg_pkg::ST_ADV_MUL: if (rsp.done) state_nxt = mrrg_pkg::ST_DIV_START;
      mrrg_pkg::ST_DIV_START: state_nxt = mrrg_pkg::ST_DIV_WAIT;
      mrrg_pkg::ST_DIV_WAIT: if (rsp.done) state_nxt = mrrg_pkg::ST_RAMP_CHK;
      mrrg_pkg::ST_RAMP_CHK: state_nxt = slope_nz ? mrrg_pkg::ST_EMIT : mrrg_pkg::ST_IDLE;
      mrrg_pkg::ST_EMIT: begin
        if (slot_free) state_nxt = going ? mrrg_pkg::ST_SCH_MUL : mrrg_pkg::ST_IDLE;
      end
      mrrg_pkg::ST_SCH_MUL: if (rsp.done) state_nxt = mrrg_pkg::ST_IDLE;
      default: state_nxt = mrrg_pkg::ST_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    grain_nxt     = cfg_we ? cfg_wdata : grain_r;
    current_nxt   = current_r;
    target_nxt    = target_r;
    slope_nxt     = slope_r;
    last_nxt      = last_r;
    pending_nxt   = pending_r;
    due_nxt       = due_r;
    sched_nxt     = sched_r;
    lvl_nxt       = lvl_r;
    tm_nxt        = tm_r;
    dur_nxt       = dur_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    req.start     = 1'b0;
    req.op        = mrrg_pkg::UOP_MUL;
    req.opa       = '0;
    req.opb       = '0;
    unique case (state_r)
      mrrg_pkg::ST_IDLE: begin
        if (in_valid) begin
          tm_nxt  = in_data.time_ms;
          dur_nxt = in_data.duration_ms;
          unique case (in_data.action)
            mrrg_pkg::ACT_JUMP: begin
              pending_nxt = 1'b0;
              current_nxt = in_data.value;
              target_nxt  = in_data.value;
              lvl_nxt     = in_data.value;
            end
            mrrg_pkg::ACT_RAMP: begin
              target_nxt = in_data.value;
              if (in_data.duration_ms == 24'd0) begin
                pending_nxt = 1'b0;
                current_nxt = in_data.value;
                lvl_nxt     = in_data.value;
              end else if (pending_r) begin
                req.start = 1'b1;
                req.op    = mrrg_pkg::UOP_MUL;
                req.opa   = {1'b0, slope_mag};
                req.opb   = adv_ms;
              end
            end
            mrrg_pkg::ACT_STOP: pending_nxt = 1'b0;
            mrrg_pkg::ACT_SET: begin
              pending_nxt = 1'b0;
              current_nxt = in_data.value;
            end
            mrrg_pkg::ACT_TICK: begin
              if (pending_r && reached) begin
                pending_nxt = 1'b0;
                lvl_nxt     = sched_r;
                tm_nxt      = due_r;
              end
            end
            default: ;
          endcase
        end
      end
      mrrg_pkg::ST_ADV_MUL: begin
        if (rsp.done) current_nxt = add_fin(current_r, slope_neg, rsp.result);
      end
      mrrg_pkg::ST_DIV_START: begin
        req.start = 1'b1;
        req.op    = mrrg_pkg::UOP_DIV;
        req.opa   = {dmag, 16'd0};
        req.opb   = {8'd0, dur_r};
      end
      mrrg_pkg::ST_DIV_WAIT: begin
        if (rsp.done) begin
          slope_nxt   = slope_div;
          pending_nxt = 1'b0;
        end
      end
      mrrg_pkg::ST_RAMP_CHK: lvl_nxt = current_r;
      mrrg_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_time_ms = tm_r;
          last_nxt                 = tm_r;
          if (slope_nz && !going) begin
            out_data_nxt.out_value = target_r;
            current_nxt            = target_r;
            pending_nxt            = 1'b0;
          end else begin
            out_data_nxt.out_value = lvl_r;
            current_nxt            = lvl_r;
          end
          if (going) begin
            pending_nxt = 1'b1;
            due_nxt     = tm_r + {16'd0, g_eff};
            req.start   = 1'b1;
            req.op      = mrrg_pkg::UOP_MUL;
            req.opa     = {1'b0, slope_mag};
            req.opb     = {16'd0, g_eff};
          end
        end
      end
      mrrg_pkg::ST_SCH_MUL: begin
        if (rsp.done) sched_nxt = add_fin(current_r, slope_neg, rsp.result);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrrg_pkg::ST_IDLE;
      grain_r     <= mrrg_pkg::GRAIN_RESET;
      current_r   <= '0;
      target_r    <= '0;
      slope_r     <= '0;
      last_r      <= '0;
      pending_r   <= 1'b0;
      due_r       <= '0;
      sched_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grain_r     <= grain_nxt;
      current_r   <= current_nxt;
      target_r    <= target_nxt;
      slope_r     <= slope_nxt;
      last_r      <= last_nxt;
      pending_r   <= pending_nxt;
      due_r       <= due_nxt;
      sched_r     <= sched_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lvl_r      <= lvl_nxt;
    tm_r       <= tm_nxt;
    dur_r      <= dur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == mrrg_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_pending_has_slope: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r && state_r == mrrg_pkg::ST_IDLE) |-> slope_nz)
    else $error("step pending with zero slope");
  a_sched_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrrg_pkg::ST_SCH_MUL) |-> pending_r)
    else $error("scheduling without a pending step");
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == mrrg_pkg::ST_ADV_MUL || state_r == mrrg_pkg::ST_DIV_WAIT ||
                  state_r == mrrg_pkg::ST_SCH_MUL))
    else $error("unit result in unexpected state");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result item dropped before it was taken");
`endif

endmodule
`default_nettype wire
